>>> hw/rtl/encvel_pkg.sv
package encvel_pkg;

  localparam int COUNT_W    = 32;
  localparam int TIME_W     = 32;
  localparam int VEL_W      = 48;
  localparam int WEIGHT_W   = 16;
  localparam int SCALE_W    = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SCALE  = CFG_IDX_W'(1);

  // 1000000 * 2^16 = 15625 * 2^22
  localparam int MULT_W     = 14;
  localparam logic [MULT_W-1:0] RATE_MULT = MULT_W'(15625);
  localparam int FRAC_SHIFT = 22;
  localparam int PROD0_W    = COUNT_W + SCALE_W;
  localparam int M_W        = 61;
  localparam int DVD_W      = M_W + FRAC_SHIFT;
  localparam int DIV_STEPS  = DVD_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
  localparam int BLEND_W    = 66;

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_MAG    = 10'b0000000010,
    S_MUL1   = 10'b0000000100,
    S_MUL2   = 10'b0000001000,
    S_DIV    = 10'b0000010000,
    S_SAT    = 10'b0000100000,
    S_BLEND1 = 10'b0001000000,
    S_BLEND2 = 10'b0010000000,
    S_SUM    = 10'b0100000000,
    S_FINISH = 10'b1000000000
  } state_t;

  typedef struct packed {
    logic load;
    logic mag;
    logic mul1;
    logic mul2;
    logic div_step;
    logic sat;
    logic blend1;
    logic blend2;
    logic sum;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic op_clear;
    logic dt_zero;
    logic out_free;
  } status_t;

endpackage

>>> hw/rtl/encvel_if.sv
interface encvel_sample_if import encvel_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              operation;
  logic [COUNT_W-1:0] position_count;
  logic [TIME_W-1:0]  time_micros;

  modport source (output valid, operation, position_count, time_micros, input ready);
  modport sink (input valid, operation, position_count, time_micros, output ready);
endinterface

interface encvel_result_if import encvel_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [VEL_W-1:0] velocity;
  logic                    zero_interval;

  modport source (output valid, velocity, zero_interval, input ready);
  modport sink (input valid, velocity, zero_interval, output ready);
endinterface

interface encvel_cfg_if import encvel_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> hw/rtl/encvel_ctrl.sv
module encvel_ctrl import encvel_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state, state_next;
  logic [DIV_CNT_W-1:0] count;

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_MAG;
        end
      end
      S_MAG: begin
        cmd.mag = 1'b1;
        if (status.op_clear || status.dt_zero) begin
          state_next = S_FINISH;
        end else begin
          state_next = S_MUL1;
        end
      end
      S_MUL1: begin
        cmd.mul1   = 1'b1;
        state_next = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2   = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (count == '0) begin
          state_next = S_SAT;
        end
      end
      S_SAT: begin
        cmd.sat    = 1'b1;
        state_next = S_BLEND1;
      end
      S_BLEND1: begin
        cmd.blend1 = 1'b1;
        state_next = S_BLEND2;
      end
      S_BLEND2: begin
        cmd.blend2 = 1'b1;
        state_next = S_SUM;
      end
      S_SUM: begin
        cmd.sum    = 1'b1;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      if (state == S_MUL2) begin
        count <= DIV_CNT_W'(DIV_STEPS - 1);
      end else if (state == S_DIV) begin
        count <= count - DIV_CNT_W'(1);
      end
    end
  end

endmodule

>>> hw/rtl/encvel_datapath.sv
module encvel_datapath import encvel_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               operation,
  input  logic [COUNT_W-1:0] position_count,
  input  logic [TIME_W-1:0]  time_micros,
  input  cmd_t               cmd,
  output status_t            status,
  encvel_result_if.source    result,
  encvel_cfg_if.sink         cfg
);

  logic [WEIGHT_W-1:0]       weight;
  logic signed [SCALE_W-1:0] scale;
  logic [COUNT_W-1:0]        last_count;
  logic [TIME_W-1:0]         last_time;
  logic signed [VEL_W-1:0]   velocity;
  logic                      out_valid;

  logic                      op_q;
  logic [COUNT_W-1:0]        dc;
  logic [TIME_W-1:0]         dt;
  logic [COUNT_W-1:0]        mag_dc;
  logic [SCALE_W-1:0]        mag_sc;
  logic [TIME_W-1:0]         mag_dt;
  logic                      neg;
  logic                      zero_flag;
  logic [PROD0_W-1:0]        prod0;
  logic [DVD_W-1:0]          dvd;
  logic [TIME_W-1:0]         rem;
  logic [VEL_W-1:0]          quo;
  logic                      sticky;
  logic signed [VEL_W-1:0]   raw;
  logic signed [BLEND_W-1:0] acc;
  logic signed [BLEND_W-1:0] prod;
  logic signed [VEL_W-1:0]   out_velocity;
  logic                      out_zero;

  logic [PROD0_W+MULT_W-1:0] m_full;
  logic [TIME_W:0]           rem_sh;
  logic                      ge;
  logic [TIME_W:0]           rem_sub;
  logic [WEIGHT_W:0]         w_new;
  logic signed [BLEND_W-1:0] p_new;
  logic signed [BLEND_W-1:0] p_old;
  logic signed [BLEND_W-1:0] s_sum;
  logic signed [VEL_W-1:0]   raw_next;
  logic                      over_pos;
  logic                      over_neg;

  assign m_full  = {{MULT_W{1'b0}}, prod0} * {{PROD0_W{1'b0}}, RATE_MULT};
  assign rem_sh  = {rem, dvd[DVD_W-1]};
  assign ge      = rem_sh >= {1'b0, mag_dt};
  assign rem_sub = rem_sh - {1'b0, mag_dt};
  assign w_new   = (WEIGHT_W+1)'(1 << WEIGHT_W) - {1'b0, weight};
  assign p_new   = $signed(BLEND_W'(w_new)) * BLEND_W'(raw);
  assign p_old   = $signed(BLEND_W'(weight)) * BLEND_W'(velocity);
  assign s_sum   = acc + prod;

  assign over_pos = sticky || quo[VEL_W-1];
  assign over_neg = sticky || (quo[VEL_W-1] && (quo[VEL_W-2:0] != '0));

  always_comb begin
    if (neg) begin
      raw_next = over_neg ? {1'b1, {(VEL_W-1){1'b0}}} : -$signed(quo);
    end else begin
      raw_next = over_pos ? {1'b0, {(VEL_W-1){1'b1}}} : $signed(quo);
    end
  end

  assign status.op_clear = op_q;
  assign status.dt_zero  = (dt == '0);
  assign status.out_free = !out_valid || result.ready;

  assign cfg.ready            = 1'b1;
  assign result.valid         = out_valid;
  assign result.velocity      = out_velocity;
  assign result.zero_interval = out_zero;

  always_ff @(posedge clk) begin
    if (rst) begin
      weight     <= '0;
      scale      <= SCALE_W'(1);
      last_count <= '0;
      last_time  <= '0;
      velocity   <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg.valid) begin
        unique case (cfg.index)
          REG_WEIGHT: weight <= cfg.data[WEIGHT_W-1:0];
          REG_SCALE:  scale  <= $signed(cfg.data[SCALE_W-1:0]);
          default: ;
        endcase
      end
      if (cmd.load) begin
        last_count <= position_count;
        last_time  <= time_micros;
      end
      if (cmd.mag && op_q) begin
        velocity <= '0;
      end else if (cmd.sum) begin
        velocity <= s_sum[VEL_W+15:16];
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q <= operation;
      dc   <= position_count - last_count;
      dt   <= time_micros - last_time;
    end
    if (cmd.mag) begin
      mag_dc    <= dc[COUNT_W-1] ? -dc : dc;
      mag_sc    <= scale[SCALE_W-1] ? SCALE_W'(-scale) : SCALE_W'(scale);
      mag_dt    <= dt[TIME_W-1] ? -dt : dt;
      neg       <= dc[COUNT_W-1] ^ scale[SCALE_W-1] ^ dt[TIME_W-1];
      zero_flag <= !op_q && (dt == '0);
    end
    if (cmd.mul1) begin
      prod0 <= {{SCALE_W{1'b0}}, mag_dc} * {{COUNT_W{1'b0}}, mag_sc};
    end
    if (cmd.mul2) begin
      dvd    <= {m_full[M_W-1:0], {FRAC_SHIFT{1'b0}}};
      rem    <= '0;
      quo    <= '0;
      sticky <= 1'b0;
    end
    if (cmd.div_step) begin
      dvd    <= {dvd[DVD_W-2:0], 1'b0};
      rem    <= ge ? rem_sub[TIME_W-1:0] : rem_sh[TIME_W-1:0];
      quo    <= {quo[VEL_W-2:0], ge};
      sticky <= sticky | quo[VEL_W-1];
    end
    if (cmd.sat) begin
      raw <= raw_next;
    end
    if (cmd.blend1) begin
      acc <= p_new;
    end
    if (cmd.blend2) begin
      prod <= p_old;
    end
    if (cmd.emit) begin
      out_velocity <= velocity;
      out_zero     <= zero_flag;
    end
  end

endmodule

>>> hw/rtl/encvel_top.sv
// encoder_velocity_ema_top: one result word per sample word.
// An update passes through the 83-step bit-serial restoring divider before its result
// is valid; a clear or zero interval skips the multiply, divide and blend states.
// One sample is processed at a time; a new sample is accepted the cycle after the
// result is written into the output register, and that write waits while the output
// register still holds a result that has not been taken.
// Reset (rst, synchronous): velocity and stored sample zero, weight 0, scale 1.
module encoder_velocity_ema_top import encvel_pkg::*; (
  input logic          clk,
  input logic          rst,
  encvel_sample_if.sink   sample,
  encvel_result_if.source result,
  encvel_cfg_if.sink      cfg
);

  cmd_t    cmd;
  status_t status;

  encvel_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (sample.valid),
    .in_ready (sample.ready),
    .status   (status),
    .cmd      (cmd)
  );

  encvel_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .operation      (sample.operation),
    .position_count (sample.position_count),
    .time_micros    (sample.time_micros),
    .cmd            (cmd),
    .status         (status),
    .result         (result),
    .cfg            (cfg)
  );

endmodule

>>> hw/rtl/encvel_checker.sv
module encvel_checker import encvel_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [VEL_W-1:0]   out_velocity,
  input logic               out_zero
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("sample accepted while busy");

  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result without sample in flight");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_velocity) && $stable(out_zero)))
    else $error("stalled result changed");

endmodule

bind encoder_velocity_ema_top encvel_checker u_encvel_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (sample.valid),
  .in_ready     (sample.ready),
  .out_valid    (result.valid),
  .out_ready    (result.ready),
  .out_velocity (result.velocity),
  .out_zero     (result.zero_interval)
);

>>> verif/tb.sv
`timescale 1ns / 100ps

module tb;
  import encvel_pkg::*;

  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  localparam logic signed [VEL_W-1:0] VEL_MAX = {1'b0, {(VEL_W-1){1'b1}}};
  localparam logic signed [VEL_W-1:0] VEL_MIN = {1'b1, {(VEL_W-1){1'b0}}};

  localparam int CYCLE_LIMIT = 1000000;
  localparam int PHASES      = 10;
  localparam int PHASE_WORDS = 145;
  localparam int SETTLE      = 100;

  typedef struct packed {
    logic signed [VEL_W-1:0] velocity;
    logic                    zero_interval;
  } vel_word_t;

  typedef struct packed {
    logic               op;
    logic [COUNT_W-1:0] pos;
    logic [TIME_W-1:0]  tim;
    logic               known;
    logic signed [VEL_W-1:0] vel;
    logic               zi;
  } dir_row_t;

  logic clk;
  logic rst;

  encvel_sample_if sample_ch ();
  encvel_result_if result_ch ();
  encvel_cfg_if    cfg_ch ();

  encoder_velocity_ema_top i_dut (
    .clk    (clk),
    .rst    (rst),
    .sample (sample_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  logic [WEIGHT_W-1:0]       weight_m;
  logic signed [SCALE_W-1:0] scale_m;
  logic [COUNT_W-1:0]        cnt_m;
  logic [TIME_W-1:0]         tim_m;
  logic signed [VEL_W-1:0]   vel_m;

  vel_word_t vel_expect_q[$];
  int        err_cnt;
  int        cycle_cnt;
  int        stall_left;
  bit        idle_on;

  dir_row_t dir_tab [0:16];

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic vel_word_t step_estimator(input logic op,
                                               input logic [COUNT_W-1:0] pos,
                                               input logic [TIME_W-1:0] tim);
    vel_word_t               w;
    logic [COUNT_W-1:0]      dc;
    logic [TIME_W-1:0]       dt;
    logic [COUNT_W:0]        dc_mag;
    logic [TIME_W:0]         dt_mag;
    logic [SCALE_W:0]        scale_mag;
    logic [83:0]             num;
    logic [83:0]             quo;
    logic                    neg;
    logic signed [VEL_W-1:0] raw;
    logic signed [65:0]      raw_x;
    logic signed [65:0]      old_x;
    logic signed [65:0]      w_old;
    logic signed [65:0]      w_new;
    logic signed [65:0]      acc;
    w.zero_interval = 1'b0;
    if (op == OP_CLEAR) begin
      vel_m = '0;
    end else begin
      dc = pos - cnt_m;
      dt = tim - tim_m;
      if (dt == '0) begin
        w.zero_interval = 1'b1;
      end else begin
        dc_mag    = dc[COUNT_W-1] ? (33'd0 - {1'b1, dc}) : {1'b0, dc};
        dt_mag    = dt[TIME_W-1] ? (33'd0 - {1'b1, dt}) : {1'b0, dt};
        scale_mag = scale_m[SCALE_W-1] ? (17'd0 - {1'b1, scale_m}) : {1'b0, scale_m};
        neg = dc[COUNT_W-1] ^ scale_m[SCALE_W-1] ^ dt[TIME_W-1];
        num = (84'(dc_mag) * 84'(scale_mag) * 84'd15625) << FRAC_SHIFT;
        quo = num / 84'(dt_mag);
        if (quo == '0) begin
          raw = '0;
        end else if (quo >= (84'd1 << (VEL_W-1))) begin
          raw = neg ? VEL_MIN : VEL_MAX;
        end else begin
          raw = neg ? -$signed(quo[VEL_W-1:0]) : $signed(quo[VEL_W-1:0]);
        end
        raw_x = raw;
        old_x = vel_m;
        w_old = $signed({50'd0, weight_m});
        w_new = 66'sd65536 - w_old;
        acc   = w_new * raw_x + w_old * old_x;
        vel_m = acc[63:16];
      end
    end
    cnt_m = pos;
    tim_m = tim;
    w.velocity = vel_m;
    return w;
  endfunction

  task automatic drive_word(input logic op, input logic [COUNT_W-1:0] pos,
                            input logic [TIME_W-1:0] tim);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 19);
      sample_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_ch.valid          <= 1'b1;
    sample_ch.operation      <= op;
    sample_ch.position_count <= pos;
    sample_ch.time_micros    <= tim;
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
  endtask

  task automatic send_random_word();
    int                 kind;
    logic               op;
    logic [COUNT_W-1:0] pos;
    logic [TIME_W-1:0]  tim;
    kind = $urandom_range(0, 99);
    op   = (kind < 6) ? OP_CLEAR : OP_UPDATE;
    if (kind < 16) begin
      pos = $urandom;
      tim = $urandom;
    end else begin
      case ($urandom_range(0, 2))
        0: pos = cnt_m + 32'($urandom_range(0, 64)) - 32'd32;
        1: pos = cnt_m + 32'($urandom_range(0, 40000)) - 32'd20000;
        default: pos = cnt_m + $urandom;
      endcase
      if (kind < 24) begin
        tim = tim_m;
      end else if (kind < 30) begin
        tim = tim_m - 32'($urandom_range(1, 3000));
      end else if (kind < 34) begin
        tim = tim_m + $urandom;
      end else begin
        tim = tim_m + 32'($urandom_range(1, 20000));
      end
    end
    vel_expect_q.push_back(step_estimator(op, pos, tim));
    drive_word(op, pos, tim);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
    if (idx == REG_WEIGHT) weight_m = val;
    else if (idx == REG_SCALE) scale_m = val;
  endtask

  task automatic drain();
    sample_ch.valid <= 1'b0;
    while (vel_expect_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // receiver back-pressure
  initial begin
    result_ch.ready = 1'b0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (stall_left != 0) begin
        stall_left--;
        result_ch.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 11) == 0) begin
        stall_left = $urandom_range(0, 18);
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (vel_expect_q.size() == 0) begin
        err_cnt++;
        $display("%0t unexpected word: expected none, got velocity %0d zero_interval %0b",
                 $time, result_ch.velocity, result_ch.zero_interval);
      end else begin
        vel_word_t exp_w;
        exp_w = vel_expect_q.pop_front();
        if (result_ch.velocity !== exp_w.velocity) begin
          err_cnt++;
          $display("%0t velocity: expected %0d, got %0d",
                   $time, exp_w.velocity, result_ch.velocity);
        end
        if (result_ch.zero_interval !== exp_w.zero_interval) begin
          err_cnt++;
          $display("%0t zero_interval: expected %0b, got %0b",
                   $time, exp_w.zero_interval, result_ch.zero_interval);
        end
      end
    end
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) @(posedge clk);
    $display("FAIL encoder_velocity_ema_top");
    $finish;
  end

  initial begin
    vel_word_t               pred;
    logic [WEIGHT_W-1:0]     w_set;
    logic [SCALE_W-1:0]      s_set;
    rst       = 1'b1;
    err_cnt   = 0;
    cycle_cnt = 0;
    idle_on   = 1'b1;
    sample_ch.valid          = 1'b0;
    sample_ch.operation      = OP_UPDATE;
    sample_ch.position_count = '0;
    sample_ch.time_micros    = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_WEIGHT;
    cfg_ch.data  = '0;
    weight_m = '0;
    scale_m  = 16'sd1;
    cnt_m    = '0;
    tim_m    = '0;
    vel_m    = '0;

    dir_tab = '{
      '{OP_UPDATE, 32'h0000_0000, 32'h0000_0000, 1'b1, 48'sd0, 1'b1},
      '{OP_UPDATE, 32'h0000_0001, 32'h0000_0001, 1'b1, 48'sd65536000000, 1'b0},
      '{OP_UPDATE, 32'h8000_0001, 32'h0000_0002, 1'b1, VEL_MIN, 1'b0},
      '{OP_UPDATE, 32'h0000_0000, 32'h0000_0003, 1'b1, VEL_MAX, 1'b0},
      '{OP_UPDATE, 32'h0000_0000, 32'h0000_0003, 1'b1, VEL_MAX, 1'b1},
      '{OP_CLEAR,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 48'sd0, 1'b0},
      '{OP_UPDATE, 32'h0000_0000, 32'h0000_0000, 1'b1, 48'sd65536000000, 1'b0},
      '{OP_UPDATE, 32'h0000_0000, 32'h8000_0000, 1'b1, 48'sd0, 1'b0},
      '{OP_UPDATE, 32'h0000_0005, 32'h7FFF_FFFF, 1'b0, 48'sd0, 1'b0},
      '{OP_UPDATE, 32'hFFFF_FFFF, 32'h8000_03E7, 1'b0, 48'sd0, 1'b0},
      '{OP_UPDATE, 32'h1234_5678, 32'hDEAD_BEEF, 1'b0, 48'sd0, 1'b0},
      '{OP_CLEAR,  32'hA5A5_A5A5, 32'h5A5A_5A5A, 1'b1, 48'sd0, 1'b0},
      '{OP_UPDATE, 32'h5A5A_5A5A, 32'hA5A5_A5A5, 1'b0, 48'sd0, 1'b0},
      '{OP_UPDATE, 32'h5A5A_5A5B, 32'h25A5_A5A4, 1'b0, 48'sd0, 1'b0},
      '{OP_UPDATE, 32'h5A5A_5A5B, 32'h25A5_A5A5, 1'b0, 48'sd0, 1'b0},
      '{OP_CLEAR,  32'h0000_0000, 32'h0000_0000, 1'b1, 48'sd0, 1'b0},
      '{OP_UPDATE, 32'h0000_0000, 32'h0000_0000, 1'b1, 48'sd0, 1'b1}
    };

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      pred = step_estimator(dir_tab[i].op, dir_tab[i].pos, dir_tab[i].tim);
      if (dir_tab[i].known) begin
        pred.velocity      = dir_tab[i].vel;
        pred.zero_interval = dir_tab[i].zi;
      end
      vel_expect_q.push_back(pred);
      drive_word(dir_tab[i].op, dir_tab[i].pos, dir_tab[i].tim);
    end
    drain();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin
          w_set = 16'hFFFF;
          s_set = 16'h8000;
        end
        1: begin
          w_set = 16'h0000;
          s_set = 16'h7FFF;
        end
        2: begin
          w_set = 16'h8000;
          s_set = 16'h0000;
        end
        3: begin
          w_set = 16'h0001;
          s_set = 16'hFFFF;
        end
        default: begin
          w_set = 16'($urandom);
          s_set = ($urandom_range(0, 1) == 0) ?
                  16'($urandom_range(0, 16)) - 16'd8 : 16'($urandom);
        end
      endcase
      write_reg(REG_WEIGHT, w_set);
      write_reg(REG_SCALE, s_set);
      // no idling in the last phase
      if (p == PHASES - 1) idle_on = 1'b0;
      repeat (PHASE_WORDS) send_random_word();
      drain();
    end

    if (err_cnt == 0) begin
      $display("PASS encoder_velocity_ema_top");
    end else begin
      $display("FAIL encoder_velocity_ema_top");
    end
    $finish;
  end

endmodule
